### src/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and codes of the first-fit heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

  localparam int OFF_W  = 21;
  localparam int ADDR_W = 32;
  localparam logic [OFF_W-1:0] HEAP_LIMIT = OFF_W'(1024 * 1024);

  typedef logic [OFF_W-1:0] off_t;

  typedef struct packed {
    logic is_free;
    off_t payload;
    off_t start;
  } entry_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BADFREE = 2'd3
  } status_e;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic CFG_HEAP_BYTES = 1'b0;
  localparam logic CFG_BASE_ADDR  = 1'b1;

endpackage

`default_nettype wire

### src/ffa_if.sv
// ----------------------------------------------------------------------------
// ffa request and response channels
// Valid/ready channels carrying allocator requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffa_req_if;
  logic                 valid;
  logic                 ready;
  logic                 action;
  ffa_pkg::off_t        req_size;
  logic [ffa_pkg::ADDR_W-1:0] free_addr;

  modport source (output valid, action, req_size, free_addr, input ready);
  modport sink   (input valid, action, req_size, free_addr, output ready);
endinterface

interface ffa_rsp_if;
  logic                 valid;
  logic                 ready;
  logic [ffa_pkg::ADDR_W-1:0] addr;
  ffa_pkg::status_e     status;

  modport source (output valid, addr, status, input ready);
  modport sink   (input valid, addr, status, output ready);
endinterface

`default_nettype wire

### src/first_fit_heap_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over an address-ordered block table with split on
// allocate and full coalescing on free.
// ----------------------------------------------------------------------------
// One request at a time. The block table sits in a single-port-write,
// registered-read memory and one sequencer walks it: the first-fit or address
// scan reads and then evaluates each entry visited, and the table shift on a
// split or a merge reads and then writes each entry moved. Entries scanned plus
// entries moved never exceed the block count. A request ends in S_DONE, which
// waits while an earlier response is still held, and the next request is
// accepted only once the sequencer is back in S_IDLE. After reset, the S_INIT
// state writes the initial free block.
`default_nettype none

module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 24
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_idx_i,
  input  wire logic [ffa_pkg::ADDR_W-1:0] cfg_data_i,
  ffa_req_if.sink                         req,
  ffa_rsp_if.source                       rsp
);
  import ffa_pkg::*;

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);
  localparam logic [CW-1:0] ONE     = CW'(1);
  localparam logic [CW-1:0] TWO     = CW'(2);
  localparam off_t          HB      = OFF_W'(HEADER_BYTES);
  localparam logic [ADDR_W-1:0] HB32 = ADDR_W'(HEADER_BYTES);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_ARD  = 4'd2;
  localparam logic [3:0] S_AEV  = 4'd3;
  localparam logic [3:0] S_MVR  = 4'd4;
  localparam logic [3:0] S_MVW  = 4'd5;
  localparam logic [3:0] S_WINS = 4'd6;
  localparam logic [3:0] S_FRD  = 4'd7;
  localparam logic [3:0] S_FEV  = 4'd8;
  localparam logic [3:0] S_FNE  = 4'd9;
  localparam logic [3:0] S_DONE = 4'd10;

  // table memory
  entry_t          mem [MAX_BLOCKS];
  entry_t          rdata_q;
  logic [IW-1:0]   raddr;
  logic            we;
  logic [IW-1:0]   waddr;
  entry_t          wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // control and payload registers
  logic [3:0]        state_q, state_d, mvnext_q, mvnext_d;
  logic [CW-1:0]     count_q, count_d, idx_q, idx_d;
  logic [CW-1:0]     src_q, src_d, dst_q, dst_d, left_q, left_d;
  logic              mvup_q, mvup_d;
  off_t              heap_q, heap_d;
  logic [ADDR_W-1:0] base_q, base_d;
  off_t              size_q, size_d, off_q, off_d;
  logic              offok_q, offok_d;
  entry_t            prev_q, prev_d, cur_q, cur_d, pend_q, pend_d;
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  status_e           res_st_q, res_st_d;
  logic              ovalid_q, ovalid_d;
  logic [ADDR_W-1:0] oaddr_q, oaddr_d;
  status_e           ost_q, ost_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      mvnext_q <= S_DONE;
      count_q  <= ONE;
      idx_q    <= '0;
      src_q    <= '0;
      dst_q    <= '0;
      left_q   <= '0;
      mvup_q   <= 1'b0;
      heap_q   <= HEAP_LIMIT;
      base_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mvnext_q <= mvnext_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      src_q    <= src_d;
      dst_q    <= dst_d;
      left_q   <= left_d;
      mvup_q   <= mvup_d;
      heap_q   <= heap_d;
      base_q   <= base_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q     <= size_d;
    off_q      <= off_d;
    offok_q    <= offok_d;
    prev_q     <= prev_d;
    cur_q      <= cur_d;
    pend_q     <= pend_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    oaddr_q    <= oaddr_d;
    ost_q      <= ost_d;
  end

  assign req.ready  = (state_q == S_IDLE);
  assign rsp.valid  = ovalid_q;
  assign rsp.addr   = oaddr_q;
  assign rsp.status = ost_q;

  off_t              cfg_h, init_pay;
  logic [ADDR_W-1:0] off32;
  logic [OFF_W:0]    split_lim;
  logic              fit_exact, fit_split, pf, nf;

  always_comb begin
    cfg_h    = (cfg_data_i[OFF_W-1:0] > HEAP_LIMIT) ? HEAP_LIMIT : cfg_data_i[OFF_W-1:0];
    init_pay = (heap_q > HB) ? heap_q - HB : '0;
    if (cfg_we_i && cfg_idx_i == CFG_HEAP_BYTES) begin
      init_pay = (cfg_h > HB) ? cfg_h - HB : '0;
    end
    off32     = req.free_addr - base_q - HB32;
    split_lim = {1'b0, size_q} + {1'b0, HB};
    fit_exact = rdata_q.is_free && (rdata_q.payload == size_q);
    fit_split = rdata_q.is_free && ({1'b0, rdata_q.payload} > split_lim);
    pf        = (idx_q != '0) && prev_q.is_free;
    nf        = ((idx_q + ONE) < count_q) && rdata_q.is_free;
  end

  always_comb begin
    state_d    = state_q;
    mvnext_d   = mvnext_q;
    count_d    = count_q;
    idx_d      = idx_q;
    src_d      = src_q;
    dst_d      = dst_q;
    left_d     = left_q;
    mvup_d     = mvup_q;
    heap_d     = heap_q;
    base_d     = base_q;
    size_d     = size_q;
    off_d      = off_q;
    offok_d    = offok_q;
    prev_d     = prev_q;
    cur_d      = cur_q;
    pend_d     = pend_q;
    res_addr_d = res_addr_q;
    res_st_d   = res_st_q;
    ovalid_d   = ovalid_q;
    oaddr_d    = oaddr_q;
    ost_d      = ost_q;
    raddr      = idx_q[IW-1:0];
    we         = 1'b0;
    waddr      = '0;
    wdata      = '{is_free: 1'b1, payload: init_pay, start: '0};

    if (ovalid_q && rsp.ready) begin
      ovalid_d = 1'b0;
    end

    // configuration; the user must write it only while idle, the block itself does not check this
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HEAP_BYTES: begin
          heap_d  = cfg_h;
          count_d = ONE;
          we      = 1'b1;
        end
        CFG_BASE_ADDR: base_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_INIT: begin
        we      = 1'b1;
        count_d = ONE;
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          idx_d      = '0;
          size_d     = req.req_size;
          off_d      = off32[OFF_W-1:0];
          offok_d    = (off32[ADDR_W-1:OFF_W] == '0);
          res_addr_d = '0;
          state_d    = (req.action == ACT_ALLOC) ? S_ARD : S_FRD;
        end
      end
      S_ARD: begin
        if (idx_q >= count_q) begin
          res_st_d = ST_NOFIT;
          state_d  = S_DONE;
        end else begin
          state_d = S_AEV;
        end
      end
      S_AEV: begin
        if (fit_exact) begin
          we         = 1'b1;
          waddr      = idx_q[IW-1:0];
          wdata      = '{is_free: 1'b0, payload: rdata_q.payload, start: rdata_q.start};
          res_addr_d = base_q + ADDR_W'(rdata_q.start) + HB32;
          res_st_d   = ST_OK;
          state_d    = S_DONE;
        end else if (fit_split) begin
          if (count_q >= CNT_MAX) begin
            res_st_d = ST_FULL;
            state_d  = S_DONE;
          end else begin
            we         = 1'b1;
            waddr      = idx_q[IW-1:0];
            wdata      = '{is_free: 1'b0, payload: size_q, start: rdata_q.start};
            pend_d     = '{is_free: 1'b1,
                           payload: rdata_q.payload - size_q - HB,
                           start: rdata_q.start + HB + size_q};
            res_addr_d = base_q + ADDR_W'(rdata_q.start) + HB32;
            res_st_d   = ST_OK;
            src_d      = count_q - ONE;
            dst_d      = count_q;
            left_d     = count_q - idx_q - ONE;
            mvup_d     = 1'b0;
            mvnext_d   = S_WINS;
            state_d    = S_MVR;
          end
        end else begin
          idx_d   = idx_q + ONE;
          state_d = S_ARD;
        end
      end
      S_MVR: begin
        raddr = src_q[IW-1:0];
        if (left_q == '0) begin
          state_d = mvnext_q;
        end else begin
          state_d = S_MVW;
        end
      end
      S_MVW: begin
        we      = 1'b1;
        waddr   = dst_q[IW-1:0];
        wdata   = rdata_q;
        src_d   = mvup_q ? src_q + ONE : src_q - ONE;
        dst_d   = mvup_q ? dst_q + ONE : dst_q - ONE;
        left_d  = left_q - ONE;
        state_d = S_MVR;
      end
      S_WINS: begin
        we      = 1'b1;
        waddr   = IW'(idx_q + ONE);
        wdata   = pend_q;
        count_d = count_q + ONE;
        state_d = S_DONE;
      end
      S_FRD: begin
        if (idx_q >= count_q || !offok_q) begin
          res_st_d = ST_BADFREE;
          state_d  = S_DONE;
        end else begin
          state_d = S_FEV;
        end
      end
      S_FEV: begin
        raddr = IW'(idx_q + ONE);
        if (rdata_q.start != off_q) begin
          prev_d  = rdata_q;
          idx_d   = idx_q + ONE;
          state_d = S_FRD;
        end else if (rdata_q.is_free) begin
          res_st_d = ST_BADFREE;
          state_d  = S_DONE;
        end else begin
          cur_d   = rdata_q;
          state_d = S_FNE;
        end
      end
      S_FNE: begin
        we       = 1'b1;
        res_st_d = ST_OK;
        mvup_d   = 1'b1;
        mvnext_d = S_DONE;
        state_d  = S_MVR;
        priority if (pf && nf) begin
          waddr   = IW'(idx_q - ONE);
          wdata   = '{is_free: 1'b1,
                      payload: prev_q.payload + cur_q.payload + rdata_q.payload + HB + HB,
                      start: prev_q.start};
          dst_d   = idx_q;
          src_d   = idx_q + TWO;
          left_d  = count_q - idx_q - TWO;
          count_d = count_q - TWO;
        end else if (pf) begin
          waddr   = IW'(idx_q - ONE);
          wdata   = '{is_free: 1'b1, payload: prev_q.payload + cur_q.payload + HB,
                      start: prev_q.start};
          dst_d   = idx_q;
          src_d   = idx_q + ONE;
          left_d  = count_q - idx_q - ONE;
          count_d = count_q - ONE;
        end else if (nf) begin
          waddr   = idx_q[IW-1:0];
          wdata   = '{is_free: 1'b1, payload: cur_q.payload + rdata_q.payload + HB,
                      start: cur_q.start};
          dst_d   = idx_q + ONE;
          src_d   = idx_q + TWO;
          left_d  = count_q - idx_q - TWO;
          count_d = count_q - ONE;
        end else begin
          waddr   = idx_q[IW-1:0];
          wdata   = '{is_free: 1'b1, payload: cur_q.payload, start: cur_q.start};
          left_d  = '0;
        end
      end
      S_DONE: begin
        if (!ovalid_q || rsp.ready) begin
          ovalid_d = 1'b1;
          oaddr_d  = (res_st_q == ST_OK) ? res_addr_q : '0;
          ost_d    = res_st_q;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire
